### hdl/tsp_pkg.sv
package tsp_pkg;

  localparam int LANES      = 8;
  localparam int KEEP_COUNT = 5;
  localparam int TEMP_W     = 8;

  localparam int RANK_W = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int POS_W  = $clog2(2 * KEEP_COUNT);

  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic [TEMP_W-1:0]        spread_t;

  typedef temp_t round_t [LANES];
  typedef temp_t keep_list_t [KEEP_COUNT];

  // Empty-slot marker for the descending high list. The low list is held
  // bit-inverted so that it is descending too and shares this marker.
  localparam temp_t HIGH_EMPTY = {1'b1, {(TEMP_W-1){1'b0}}};

endpackage

### hdl/tsp_if.sv
interface tsp_in_if;
  logic               valid;
  logic               ready;
  tsp_pkg::temp_t     temp_lane_0;
  tsp_pkg::temp_t     temp_lane_1;
  tsp_pkg::temp_t     temp_lane_2;
  tsp_pkg::temp_t     temp_lane_3;
  tsp_pkg::temp_t     temp_lane_4;
  tsp_pkg::temp_t     temp_lane_5;
  tsp_pkg::temp_t     temp_lane_6;
  tsp_pkg::temp_t     temp_lane_7;
  logic               end_of_interval;

  modport source (
    output valid, temp_lane_0, temp_lane_1, temp_lane_2, temp_lane_3,
           temp_lane_4, temp_lane_5, temp_lane_6, temp_lane_7, end_of_interval,
    input  ready
  );
  modport sink (
    input  valid, temp_lane_0, temp_lane_1, temp_lane_2, temp_lane_3,
           temp_lane_4, temp_lane_5, temp_lane_6, temp_lane_7, end_of_interval,
    output ready
  );
endinterface

interface tsp_out_if;
  logic               valid;
  logic               ready;
  tsp_pkg::temp_t     high_first;
  tsp_pkg::temp_t     high_second;
  tsp_pkg::temp_t     high_third;
  tsp_pkg::temp_t     high_fourth;
  tsp_pkg::temp_t     high_fifth;
  tsp_pkg::temp_t     low_first;
  tsp_pkg::temp_t     low_second;
  tsp_pkg::temp_t     low_third;
  tsp_pkg::temp_t     low_fourth;
  tsp_pkg::temp_t     low_fifth;
  tsp_pkg::spread_t   largest_spread;

  modport source (
    output valid, high_first, high_second, high_third, high_fourth, high_fifth,
           low_first, low_second, low_third, low_fourth, low_fifth, largest_spread,
    input  ready
  );
  modport sink (
    input  valid, high_first, high_second, high_third, high_fourth, high_fifth,
           low_first, low_second, low_third, low_fourth, low_fifth, largest_spread,
    output ready
  );
endinterface

### hdl/tsp_lane.sv
// Rank of one sensor reading within its round (0 = highest).
// Equal readings are ordered by lane number.
module tsp_lane (
  input  tsp_pkg::round_t            temps,
  input  logic [tsp_pkg::RANK_W-1:0] lane_idx,
  output logic [tsp_pkg::RANK_W-1:0] rank
);
  import tsp_pkg::*;

  temp_t own;

  assign own = temps[lane_idx];

  always_comb begin
    rank = '0;
    for (int j = 0; j < LANES; j++) begin
      if ((temps[j] > own) || ((temps[j] == own) && (RANK_W'(j) < lane_idx))) begin
        rank = rank + RANK_W'(1);
      end
    end
  end

endmodule

### hdl/tsp_merge.sv
// Merges two descending lists and keeps the top KEEP_COUNT.
// Kept entries win ties, so each element lands on a distinct slot.
module tsp_merge (
  input  tsp_pkg::keep_list_t kept,
  input  tsp_pkg::keep_list_t fresh,
  output tsp_pkg::keep_list_t merged
);
  import tsp_pkg::*;

  logic [POS_W-1:0] pos_kept  [KEEP_COUNT];
  logic [POS_W-1:0] pos_fresh [KEEP_COUNT];

  always_comb begin
    for (int i = 0; i < KEEP_COUNT; i++) begin
      pos_kept[i]  = POS_W'(i);
      pos_fresh[i] = POS_W'(i);
      for (int j = 0; j < KEEP_COUNT; j++) begin
        if (fresh[j] > kept[i]) begin
          pos_kept[i] = pos_kept[i] + POS_W'(1);
        end
        if (kept[j] >= fresh[i]) begin
          pos_fresh[i] = pos_fresh[i] + POS_W'(1);
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < KEEP_COUNT; k++) begin
      merged[k] = '0;
      for (int i = 0; i < KEEP_COUNT; i++) begin
        if (pos_kept[i] == POS_W'(k)) begin
          merged[k] = merged[k] | kept[i];
        end
        if (pos_fresh[i] == POS_W'(k)) begin
          merged[k] = merged[k] | fresh[i];
        end
      end
    end
  end

endmodule

### hdl/temp_report_topk_spread_top.sv
// Interval temperature report. Each input beat is one round of eight signed
// sensor readings plus an end-of-interval flag. The block tracks the five
// highest and five lowest readings of the interval (duplicates counted) and
// the largest max-minus-min seen within a single round. A flagged round is
// folded in first, then one report beat is emitted and the store returns to
// empty: high slots read -128 and low slots 127 until a reading fills them.
// Rate: one round per clock, sustained, with no gaps, unless a flagged round
// waits on a held-off output. An accepted flagged round goes through stage 1,
// which sorts it across per-lane rank units, then stage 2, which merges it
// into the kept lists and loads the report beat (that merge and its feedback
// into the lists set the clock-rate path). in_ready only drops when a report
// is waiting in the output register and the sink holds it off.
module temp_report_topk_spread_top (
  input logic          clk,
  input logic          rst_n,
  tsp_in_if.sink       in_beat,
  tsp_out_if.source    out_beat
);
  import tsp_pkg::*;

  // ---------------------------------------------------------------------
  // Stage 1: per-lane ranking of the incoming round
  // ---------------------------------------------------------------------
  round_t              temps;
  logic [RANK_W-1:0]   lane_rank [LANES];
  round_t              desc;
  keep_list_t          round_hi;
  keep_list_t          round_lo_inv;   // lows, bit-inverted, descending
  logic signed [TEMP_W:0] round_diff;

  assign temps[0] = in_beat.temp_lane_0;
  assign temps[1] = in_beat.temp_lane_1;
  assign temps[2] = in_beat.temp_lane_2;
  assign temps[3] = in_beat.temp_lane_3;
  assign temps[4] = in_beat.temp_lane_4;
  assign temps[5] = in_beat.temp_lane_5;
  assign temps[6] = in_beat.temp_lane_6;
  assign temps[7] = in_beat.temp_lane_7;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    tsp_lane u_lane (
      .temps    (temps),
      .lane_idx (RANK_W'(g)),
      .rank     (lane_rank[g])
    );
  end

  // Ranks are unique, so each sorted slot picks exactly one lane.
  always_comb begin
    for (int r = 0; r < LANES; r++) begin
      desc[r] = '0;
      for (int i = 0; i < LANES; i++) begin
        if (lane_rank[i] == RANK_W'(r)) begin
          desc[r] = desc[r] | temps[i];
        end
      end
    end
  end

  // Only the top/bottom KEEP_COUNT of a round can reach the lists.
  always_comb begin
    for (int k = 0; k < KEEP_COUNT; k++) begin
      if (k < LANES) begin
        round_hi[k]     = desc[k];
        round_lo_inv[k] = ~desc[LANES-1-k];
      end else begin
        round_hi[k]     = HIGH_EMPTY;
        round_lo_inv[k] = HIGH_EMPTY;
      end
    end
  end

  // Max minus min of the round; never negative and never above 255.
  assign round_diff = {desc[0][TEMP_W-1], desc[0]}
                    - {desc[LANES-1][TEMP_W-1], desc[LANES-1]};

  // ---------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------
  logic       s1_v_r,  s1_v_nxt;
  logic       s1_eoi_r, s1_eoi_nxt;
  keep_list_t s1_hi_r, s1_hi_nxt;
  keep_list_t s1_lo_r, s1_lo_nxt;
  spread_t    s1_spread_r, s1_spread_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       s2_fire;
  logic       in_fire;

  assign out_free = !out_valid_r || out_beat.ready;
  // A plain round never needs the output; a flagged one waits for a free slot.
  assign s2_fire  = s1_v_r && (!s1_eoi_r || out_free);
  assign in_beat.ready = !s1_v_r || s2_fire;
  assign in_fire  = in_beat.valid && in_beat.ready;

  always_comb begin
    s1_v_nxt      = in_fire ? 1'b1 : (s2_fire ? 1'b0 : s1_v_r);
    s1_eoi_nxt    = in_fire ? in_beat.end_of_interval : s1_eoi_r;
    s1_hi_nxt     = in_fire ? round_hi : s1_hi_r;
    s1_lo_nxt     = in_fire ? round_lo_inv : s1_lo_r;
    s1_spread_nxt = in_fire ? round_diff[TEMP_W-1:0] : s1_spread_r;
  end

  // ---------------------------------------------------------------------
  // Stage 2: merge into the interval store
  // ---------------------------------------------------------------------
  keep_list_t hi_r,     hi_nxt;
  keep_list_t lo_inv_r, lo_inv_nxt;
  spread_t    best_r,   best_nxt;
  keep_list_t mrg_hi;
  keep_list_t mrg_lo_inv;
  spread_t    best_upd;

  keep_list_t out_hi_r, out_hi_nxt;
  keep_list_t out_lo_r, out_lo_nxt;
  spread_t    out_spread_r, out_spread_nxt;

  tsp_merge u_merge_hi (
    .kept   (hi_r),
    .fresh  (s1_hi_r),
    .merged (mrg_hi)
  );

  tsp_merge u_merge_lo (
    .kept   (lo_inv_r),
    .fresh  (s1_lo_r),
    .merged (mrg_lo_inv)
  );

  assign best_upd = (s1_spread_r > best_r) ? s1_spread_r : best_r;

  always_comb begin
    hi_nxt         = hi_r;
    lo_inv_nxt     = lo_inv_r;
    best_nxt       = best_r;
    out_hi_nxt     = out_hi_r;
    out_lo_nxt     = out_lo_r;
    out_spread_nxt = out_spread_r;
    out_valid_nxt  = out_beat.ready ? 1'b0 : out_valid_r;

    if (s2_fire) begin
      if (s1_eoi_r) begin
        // Report the interval including this round, then empty the store.
        out_hi_nxt     = mrg_hi;
        for (int k = 0; k < KEEP_COUNT; k++) begin
          out_lo_nxt[k] = ~mrg_lo_inv[k];
          hi_nxt[k]     = HIGH_EMPTY;
          lo_inv_nxt[k] = HIGH_EMPTY;
        end
        out_spread_nxt = best_upd;
        out_valid_nxt  = 1'b1;
        best_nxt       = '0;
      end else begin
        hi_nxt     = mrg_hi;
        lo_inv_nxt = mrg_lo_inv;
        best_nxt   = best_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      best_r      <= '0;
      for (int k = 0; k < KEEP_COUNT; k++) begin
        hi_r[k]     <= HIGH_EMPTY;
        lo_inv_r[k] <= HIGH_EMPTY;
      end
    end else begin
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
      best_r      <= best_nxt;
      hi_r        <= hi_nxt;
      lo_inv_r    <= lo_inv_nxt;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    s1_eoi_r     <= s1_eoi_nxt;
    s1_hi_r      <= s1_hi_nxt;
    s1_lo_r      <= s1_lo_nxt;
    s1_spread_r  <= s1_spread_nxt;
    out_hi_r     <= out_hi_nxt;
    out_lo_r     <= out_lo_nxt;
    out_spread_r <= out_spread_nxt;
  end

  // ---------------------------------------------------------------------
  // Output beat
  // ---------------------------------------------------------------------
  assign out_beat.valid          = out_valid_r;
  assign out_beat.high_first     = out_hi_r[0];
  assign out_beat.high_second    = out_hi_r[1];
  assign out_beat.high_third     = out_hi_r[2];
  assign out_beat.high_fourth    = out_hi_r[3];
  assign out_beat.high_fifth     = out_hi_r[4];
  assign out_beat.low_first      = out_lo_r[0];
  assign out_beat.low_second     = out_lo_r[1];
  assign out_beat.low_third      = out_lo_r[2];
  assign out_beat.low_fourth     = out_lo_r[3];
  assign out_beat.low_fifth      = out_lo_r[4];
  assign out_beat.largest_spread = out_spread_r;

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

// Interval report bench: rounds of eight readings go in, one report beat
// comes out per flagged round. A local model of the kept lists predicts
// every untyped report. Reports queue in order and are compared field by field.
module tb_top;
  import tsp_pkg::*;

  // One report as it leaves the block: kept highs, kept lows, widest spread
  typedef struct {
    temp_t   high[KEEP_COUNT];
    temp_t   low[KEEP_COUNT];
    spread_t spread;
  } report_t;

  // Directed stimulus row; want is only used where typed is set
  typedef struct {
    round_t  lanes;
    logic    eoi;
    bit      typed;
    report_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  tsp_in_if  in_if ();
  tsp_out_if out_if ();

  temp_report_topk_spread_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (in_if),
    .out_beat (out_if)
  );

  // Model of the interval store
  keep_list_t kept_high;
  keep_list_t kept_low;
  spread_t    widest_spread;

  report_t   pending_reports[$];
  stim_row_t stim_table[$];
  report_t   blank_report;

  int faults = 0;
  bit no_idle = 1'b0;   // both sides run flat out
  bit burst = 1'b0;     // sender offers flagged rounds back to back
  bit hold_req = 1'b0;  // asks the sink for one long hold-off

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("temp_report_topk_spread_top regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Model
  // ---------------------------------------------------------------------

  function automatic void clear_store();
    for (int i = 0; i < KEEP_COUNT; i++) begin
      kept_high[i] = -128;
      kept_low[i]  = 127;
    end
    widest_spread = '0;
  endfunction

  // Insert v ahead of the first entry it beats; equal values stay behind
  function automatic keep_list_t ranked(keep_list_t list, temp_t v, bit ascending);
    bit placed;
    bit beats;
    placed = 1'b0;
    for (int p = 0; p < KEEP_COUNT; p++) begin
      beats = ascending ? (v < list[p]) : (v > list[p]);
      if (!placed && beats) begin
        for (int q = KEEP_COUNT - 1; q > p; q--) list[q] = list[q-1];
        list[p] = v;
        placed = 1'b1;
      end
    end
    return list;
  endfunction

  // Folds one round into the store; returns 1 with the report on a flagged round
  function automatic bit fold_round(input round_t r, input logic eoi,
                                    output report_t rpt);
    int hi;
    int lo;
    hi = -128;
    lo = 127;
    rpt = blank_report;
    for (int i = 0; i < LANES; i++) begin
      if (int'(r[i]) > hi) hi = r[i];
      if (int'(r[i]) < lo) lo = r[i];
      kept_high = ranked(kept_high, r[i], 1'b0);
      kept_low  = ranked(kept_low, r[i], 1'b1);
    end
    if (hi - lo > int'(widest_spread)) widest_spread = spread_t'(hi - lo);
    if (eoi !== 1'b1) return 1'b0;
    rpt.high   = kept_high;
    rpt.low    = kept_low;
    rpt.spread = widest_spread;
    clear_store();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic report_t report_of(keep_list_t h, keep_list_t l, spread_t s);
    report_t rpt;
    rpt.high   = h;
    rpt.low    = l;
    rpt.spread = s;
    return rpt;
  endfunction

  function automatic void add_row(round_t r, logic eoi, bit typed, report_t want);
    stim_row_t row;
    row.lanes = r;
    row.eoi   = eoi;
    row.typed = typed;
    row.want  = want;
    stim_table.insert(stim_table.size(), row);
  endfunction

  // Mix of fully random, extreme, clustered (many ties) and uniform rounds
  function automatic round_t draw_round();
    round_t r;
    int style;
    int base;
    int val;
    int extremes[6];
    extremes = '{-128, 127, -127, 126, 0, -1};
    style = $urandom_range(0, 9);
    base  = int'($urandom_range(0, 255)) - 128;
    for (int i = 0; i < LANES; i++) begin
      if (style <= 4) begin
        r[i] = temp_t'($urandom_range(0, 255));
      end else if (style <= 6) begin
        r[i] = temp_t'(extremes[$urandom_range(0, 5)]);
      end else if (style <= 8) begin
        val = base + int'($urandom_range(0, 4)) - 2;
        if (val > 127) val = 127;
        if (val < -128) val = -128;
        r[i] = temp_t'(val);
      end else begin
        r[i] = temp_t'(base);
      end
    end
    return r;
  endfunction

  // Offer one round; the model is stepped on the accepting edge
  task automatic send_round(input round_t r, input logic eoi, input bit typed,
                            input report_t want);
    int gap;
    report_t predicted;
    gap = (no_idle || burst) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid           <= 1'b1;
    in_if.temp_lane_0     <= r[0];
    in_if.temp_lane_1     <= r[1];
    in_if.temp_lane_2     <= r[2];
    in_if.temp_lane_3     <= r[3];
    in_if.temp_lane_4     <= r[4];
    in_if.temp_lane_5     <= r[5];
    in_if.temp_lane_6     <= r[6];
    in_if.temp_lane_7     <= r[7];
    in_if.end_of_interval <= eoi;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    if (fold_round(r, eoi, predicted)) begin
      if (typed) pending_reports.insert(pending_reports.size(), want);
      else pending_reports.insert(pending_reports.size(), predicted);
    end
  endtask

  // Sender goes quiet until every report owed has arrived
  task automatic drain_all();
    if (pending_reports.size() != 0) begin
      in_if.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clk);
    end
  endtask

  task automatic note_mismatch(string field, int idx, int want_v, int got_v);
    faults++;
    if (faults <= 10)
      $display("%0t: report %s[%0d] expected %0d got %0d", $realtime, field, idx,
               want_v, got_v);
  endtask

  task automatic check_report(report_t want, report_t got);
    for (int i = 0; i < KEEP_COUNT; i++) begin
      if (got.high[i] !== want.high[i]) note_mismatch("high", i, want.high[i], got.high[i]);
      if (got.low[i] !== want.low[i]) note_mismatch("low", i, want.low[i], got.low[i]);
    end
    if (got.spread !== want.spread) note_mismatch("spread", 0, want.spread, got.spread);
  endtask

  // ---------------------------------------------------------------------
  // Sink side: random stalls, one long hold-off on request, checks every beat
  // ---------------------------------------------------------------------
  initial begin : sink_side
    report_t got;
    int stall;
    out_if.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 8);
      if (hold_req) begin
        // long back-pressure so the output register and pipeline fill
        stall = 300;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
      got.high[0] = out_if.high_first;
      got.high[1] = out_if.high_second;
      got.high[2] = out_if.high_third;
      got.high[3] = out_if.high_fourth;
      got.high[4] = out_if.high_fifth;
      got.low[0]  = out_if.low_first;
      got.low[1]  = out_if.low_second;
      got.low[2]  = out_if.low_third;
      got.low[3]  = out_if.low_fourth;
      got.low[4]  = out_if.low_fifth;
      got.spread  = out_if.largest_spread;
      if (pending_reports.size() == 0) begin
        faults++;
        if (faults <= 10) $display("%0t: report beat with none expected", $realtime);
      end else begin
        check_report(pending_reports.pop_front(), got);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Source side: reset, directed table, random rounds, final drain
  // ---------------------------------------------------------------------
  initial begin : source_side
    int spin;
    logic eoi;
    rst_n                 <= 1'b0;
    in_if.valid           <= 1'b0;
    in_if.temp_lane_0     <= '0;
    in_if.temp_lane_1     <= '0;
    in_if.temp_lane_2     <= '0;
    in_if.temp_lane_3     <= '0;
    in_if.temp_lane_4     <= '0;
    in_if.temp_lane_5     <= '0;
    in_if.temp_lane_6     <= '0;
    in_if.temp_lane_7     <= '0;
    in_if.end_of_interval <= 1'b0;
    clear_store();
    blank_report = report_of('{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0}, 0);

    // Lone flagged rounds straight after reset: report covers that round only.
    // All -128 equals the high sentinel, so the highs cannot be told from empty.
    add_row('{-128, -128, -128, -128, -128, -128, -128, -128}, 1'b1, 1'b1,
            report_of('{-128, -128, -128, -128, -128}, '{-128, -128, -128, -128, -128}, 0));
    add_row('{127, 127, 127, 127, 127, 127, 127, 127}, 1'b1, 1'b1,
            report_of('{127, 127, 127, 127, 127}, '{127, 127, 127, 127, 127}, 0));
    // both extremes in one round: full-scale spread
    add_row('{127, -128, 127, -128, 127, -128, 127, -128}, 1'b1, 1'b1,
            report_of('{127, 127, 127, 127, -128}, '{-128, -128, -128, -128, 127}, 255));
    add_row('{0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, 1'b1,
            report_of('{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0}, 0));
    add_row('{1, 2, 3, 4, 5, 6, 7, 8}, 1'b1, 1'b1,
            report_of('{8, 7, 6, 5, 4}, '{1, 2, 3, 4, 5}, 7));
    add_row('{-1, -2, -3, -4, -5, -6, -7, -8}, 1'b1, 1'b1,
            report_of('{-1, -2, -3, -4, -5}, '{-8, -7, -6, -5, -4}, 7));
    // multi-round intervals: the flagged round carries the widest spread
    add_row('{100, -100, 50, -50, 25, -25, 0, 0}, 1'b0, 1'b0, blank_report);
    add_row('{10, 11, 12, 13, 14, 15, 16, 17}, 1'b0, 1'b0, blank_report);
    add_row('{126, -127, 3, 3, 3, 3, 3, 3}, 1'b1, 1'b0, blank_report);
    // ties: equal readings each take a slot
    add_row('{5, 5, 5, 5, 5, 5, 5, 5}, 1'b0, 1'b0, blank_report);
    add_row('{5, 5, 5, 5, 5, 5, 5, 6}, 1'b1, 1'b0, blank_report);
    add_row('{127, 127, 127, 127, 127, 127, 127, -128}, 1'b0, 1'b0, blank_report);
    add_row('{-128, -128, -128, -128, -128, -128, -128, 127}, 1'b1, 1'b0, blank_report);
    add_row('{64, -64, 32, -32, 16, -16, 8, -8}, 1'b0, 1'b0, blank_report);
    add_row('{-3, -3, -3, -3, -3, -3, -3, -3}, 1'b0, 1'b0, blank_report);
    add_row('{0, 1, -1, 2, -2, 3, -3, 4}, 1'b1, 1'b0, blank_report);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_table[k])
      send_round(stim_table[k].lanes, stim_table[k].eoi, stim_table[k].typed,
                 stim_table[k].want);
    drain_all();

    for (int item = 0; item < 500; item++) begin
      if (item % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      // back-to-back flagged rounds against a long sink hold-off
      if (item == 150) begin
        burst = 1'b1;
        hold_req = 1'b1;
      end
      if (item == 175) burst = 1'b0;
      // sender waits until every report owed has arrived before carrying on
      if (item == 320) drain_all();
      eoi = burst ? 1'b1 : ($urandom_range(0, 5) == 0);
      send_round(draw_round(), eoi, 1'b0, blank_report);
    end
    in_if.valid <= 1'b0;

    spin = 0;
    while (pending_reports.size() != 0 && spin < 2000) begin
      @(posedge clk);
      spin++;
    end
    if (pending_reports.size() != 0) begin
      faults += pending_reports.size();
      $display("%0d report beats never arrived", pending_reports.size());
    end
    // keep clocking to catch any stray beat
    repeat (8) @(posedge clk);

    if (faults == 0) begin
      $display("temp_report_topk_spread_top regression: pass");
    end else begin
      $display("temp_report_topk_spread_top regression: fail");
    end
    $finish;
  end

endmodule
